// File: rtl/core/itra_pkg.sv
// Package for the integer to radix ASCII converter.
// Holds radix limits, ASCII codes and the digit to character mapping.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

	localparam int RADIX_W = 6;

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;

	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_MINUS   = 8'h2d;

	typedef logic [RADIX_W-1:0] radix_t;
	typedef logic [7:0]         char_t;

	// digit value (below 36) to its ASCII code
	function automatic char_t digit_char(radix_t d, logic upper);
		char_t base;
		begin
			if (d < RADIX_DEFAULT) begin
				digit_char = ASCII_ZERO + {2'b00, d};
			end else begin
				base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
				digit_char = base + {2'b00, d - RADIX_DEFAULT};
			end
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/itra_div.sv
// Bit-serial restoring divider: VALUE_WIDTH-bit dividend by a 6-bit radix.
// One quotient bit per cycle; depends on itra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itra_div #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire [VALUE_WIDTH-1:0]    dividend,
	input  wire itra_pkg::radix_t    divisor,
	output logic                     done,
	output logic [VALUE_WIDTH-1:0]   quotient,
	output itra_pkg::radix_t         remainder
);
	import itra_pkg::*;

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	radix_t                 rem_q;
	radix_t                 div_q;

	logic [RADIX_W:0] trial;
	logic             fits;

	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so six bits hold it
			rem_q <= fits ? RADIX_W'(trial - {1'b0, div_q}) : trial[RADIX_W-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/integer_to_radix_ascii.sv
// Top level of the integer to radix ASCII converter.
// Uses itra_pkg and the serial divider itra_div; digit stack held locally.
//
//  channel | signals                               | dir | meaning
//  --------+---------------------------------------+-----+---------------------------
//  num     | num_valid num_ready value radix       | in  | one request: value to print
//          | upper_case                            |     |
//  chr     | chr_valid chr_ready character last    | out | one ASCII char, last marked
//
// Each digit takes one pass of the serial divider (one quotient bit a cycle),
// digits go onto a stack, then each character is read out (memory read, then
// present). A minus sign, if any, goes out before the digits. num_ready is
// high only when idle.
// A stall on chr holds the current character. Reset returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           num_valid,
	output logic                          num_ready,
	input  wire signed [VALUE_WIDTH-1:0]  value,
	input  wire itra_pkg::radix_t         radix,
	input  wire                           upper_case,
	output logic                          chr_valid,
	input  wire                           chr_ready,
	output itra_pkg::char_t               character,
	output logic                          last
);
	import itra_pkg::*;

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int IDX_W = $clog2(VALUE_WIDTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MINUS = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       nd_q;
	logic [VALUE_WIDTH-1:0] v_q;
	radix_t                 radix_q;
	logic                   upper_q;
	logic                   neg_q;
	char_t                  rd_q;
	char_t                  digit_mem [VALUE_WIDTH];

	radix_t                 radix_eff;
	logic                   neg_in;
	logic                   accept;
	logic                   div_start;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quo;
	radix_t                 div_rem;
	logic [CNT_W-1:0]       nd_m1;
	logic                   wr_en;
	logic                   rd_en;

	always_comb begin
		if (radix inside {[RADIX_MIN:RADIX_MAX]}) begin
			radix_eff = radix;
		end else begin
			radix_eff = RADIX_DEFAULT;
		end
	end

	assign neg_in    = (radix_eff == RADIX_DEFAULT) && value[VALUE_WIDTH-1];
	assign num_ready = (state_q == ST_IDLE);
	assign accept    = num_valid && num_ready;
	assign div_start = (state_q == ST_START);
	assign nd_m1     = nd_q - CNT_W'(1);
	assign wr_en     = (state_q == ST_DIV) && div_done;
	assign rd_en     = (state_q == ST_RD);

	itra_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q),
		.divisor  (radix_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nd_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						nd_q    <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						nd_q <= nd_q + CNT_W'(1);
						if (div_quo != '0) begin
							state_q <= ST_START;
						end else if (neg_q) begin
							state_q <= ST_MINUS;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_MINUS: begin
					if (chr_ready) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					nd_q    <= nd_m1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (chr_ready) begin
						state_q <= (nd_q == '0) ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and working value
	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q <= radix_eff;
			upper_q <= upper_case;
			neg_q   <= neg_in;
			v_q     <= neg_in ? (~value + VALUE_WIDTH'(1)) : value;
		end else if (wr_en) begin
			v_q <= div_quo;
		end
	end

	// digit stack, least significant digit at the bottom
	always_ff @(posedge clk) begin
		if (wr_en) begin
			digit_mem[nd_q[IDX_W-1:0]] <= digit_char(div_rem, upper_q);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= digit_mem[nd_m1[IDX_W-1:0]];
		end
	end

	assign chr_valid = (state_q == ST_MINUS) || (state_q == ST_OUT);
	assign character = (state_q == ST_MINUS) ? ASCII_MINUS : rd_q;
	assign last      = (state_q == ST_OUT) && (nd_q == '0);

	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid |-> !num_ready)
		else $error("request taken while characters pending");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nd_q <= CNT_W'(VALUE_WIDTH))
		else $error("digit stack overflow");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside of divide state");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(chr_valid && chr_ready && last) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after last character");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for integer_to_radix_ascii: directed, radix sweep and random requests.
// Predicts the digit string of each request and checks every character in order.
// Depends on itra_pkg and the integer_to_radix_ascii RTL.
`timescale 1ns / 1ps

module tb_top;
	import itra_pkg::*;

	localparam int VW = 32;
	localparam int IDLE_LIMIT = 10000;
	localparam int DRAIN_CYCLES = 1200;

	typedef struct packed {
		char_t character;
		logic  last;
	} char_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 num_valid = 1'b0;
	logic                 num_ready;
	logic signed [VW-1:0] value = '0;
	radix_t               radix = '0;
	logic                 upper_case = 1'b0;
	logic                 chr_valid;
	logic                 chr_ready = 1'b0;
	char_t                character;
	logic                 last;

	char_rec_t expected_chars[$];
	int errors = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_phase = 0;

	integer_to_radix_ascii #(.VALUE_WIDTH(VW)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_valid  (num_valid),
		.num_ready  (num_ready),
		.value      (value),
		.radix      (radix),
		.upper_case (upper_case),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready),
		.character  (character),
		.last       (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// queue the characters one request should produce, sign first
	function automatic void predict_digits(logic [VW-1:0] v, radix_t r, logic up);
		logic [VW-1:0] mag;
		logic [VW-1:0] d;
		int unsigned   base;
		char_t         digs [0:VW];
		int            nd;
		int            i;
		logic          neg;
		begin
			base = (r < RADIX_MIN || r > RADIX_MAX) ? 32'(RADIX_DEFAULT) : 32'(r);
			neg = (base == RADIX_DEFAULT) && v[VW-1];
			mag = neg ? -v : v;
			nd = 0;
			do begin
				d = mag % base;
				if (d < 10)
					digs[nd] = ASCII_ZERO + d[7:0];
				else
					digs[nd] = (up ? ASCII_UPPER_A : ASCII_LOWER_A) + d[7:0] - 8'd10;
				nd++;
				mag = mag / base;
			end while (mag != 0);
			if (neg)
				expected_chars.push_back('{character: ASCII_MINUS, last: 1'b0});
			for (i = nd - 1; i >= 0; i--)
				expected_chars.push_back('{character: digs[i], last: (i == 0)});
		end
	endfunction

	function automatic int pick_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: pick_gap = $urandom_range(1, 10);
			6, 7:             pick_gap = $urandom_range(11, 80);
			8:                pick_gap = $urandom_range(200, 1200);
			default:          pick_gap = $urandom_range(1, 3);
		endcase
	endfunction

	// one request; bursts of back-to-back requests, usually separated by random gaps
	task automatic send_number(input logic [VW-1:0] v, input radix_t r, input logic up);
		int gap;
		begin
			if (burst_left == 0) begin
				gap = pick_gap();
				if ($urandom_range(0, 3) != 0) begin
					num_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 8);
			end
			num_valid  <= 1'b1;
			value      <= v;
			radix      <= r;
			upper_case <= up;
			do @(posedge clk); while (!num_ready);
			predict_digits(v, r, up);
			burst_left--;
		end
	endtask

	task automatic test_directed();
		begin
			send_number(32'd0, 6'd10, 1'b0);
			send_number(32'd1, 6'd10, 1'b0);
			send_number(-32'sd1, 6'd10, 1'b0);
			send_number(32'h7fffffff, 6'd10, 1'b0);
			send_number(32'h80000000, 6'd10, 1'b1);
			send_number(-32'sd2147483647, 6'd10, 1'b0);
			send_number(32'd9, 6'd10, 1'b1);
			send_number(32'hffffffff, 6'd2, 1'b0);
			send_number(32'h80000000, 6'd2, 1'b1);
			send_number(32'h7fffffff, 6'd2, 1'b0);
			send_number(32'd0, 6'd2, 1'b0);
			send_number(32'hffffffff, 6'd16, 1'b1);
			send_number(32'hdeadbeef, 6'd16, 1'b0);
			send_number(32'hdeadbeef, 6'd16, 1'b1);
			send_number(32'd35, 6'd36, 1'b1);
			send_number(32'd35, 6'd36, 1'b0);
			send_number(32'hffffffff, 6'd36, 1'b1);
			send_number(32'h80000000, 6'd8, 1'b0);
			send_number(32'd10, 6'd11, 1'b0);
			send_number(32'd12345, 6'd3, 1'b0);
			// out-of-range radix falls back to base ten, sign included
			send_number(-32'sd12345, 6'd0, 1'b0);
			send_number(32'd255, 6'd1, 1'b1);
			send_number(32'd255, 6'd37, 1'b1);
			send_number(-32'sd255, 6'd63, 1'b0);
		end
	endtask

	function automatic logic [VW-1:0] pick_value();
		case ($urandom_range(0, 5))
			0, 5: pick_value = $urandom;
			1:    pick_value = $urandom_range(0, 100);
			2:    pick_value = -$urandom_range(1, 100);
			3:    pick_value = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
			default: begin
				case ($urandom_range(0, 3))
					0:       pick_value = 32'h7fffffff;
					1:       pick_value = 32'h80000000;
					2:       pick_value = 32'd0;
					default: pick_value = 32'hffffffff;
				endcase
			end
		endcase
	endfunction

	task automatic test_radix_sweep();
		int r;
		begin
			for (r = 0; r < 64; r++)
				send_number(pick_value(), radix_t'(r), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_random(input int count);
		int n;
		radix_t r;
		begin
			for (n = 0; n < count; n++) begin
				if ($urandom_range(0, 4) != 0)
					r = radix_t'($urandom_range(2, 36));
				else
					r = radix_t'($urandom_range(0, 63));
				send_number(pick_value(), r, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// character checker and receiver stall pattern
	always @(posedge clk) begin
		char_rec_t exp_rec;
		if (arst_n && chr_valid && chr_ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t unexpected character: exp none, got %h last %b",
					$time, character, last);
				errors++;
			end else begin
				exp_rec = expected_chars.pop_front();
				if (character !== exp_rec.character) begin
					$display("%0t character mismatch: exp %h, got %h",
						$time, exp_rec.character, character);
					errors++;
				end
				if (last !== exp_rec.last) begin
					$display("%0t last mismatch: exp %b, got %b",
						$time, exp_rec.last, last);
					errors++;
				end
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(64, 256);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0:       chr_ready <= 1'b1;
			1:       chr_ready <= 1'($urandom_range(0, 1));
			2:       chr_ready <= (stall_phase % 3) == 0;
			default: chr_ready <= (stall_phase % 8) == 7;
		endcase
	end

	// watchdog: no request and no character moving for too long
	always @(posedge clk) begin
		if ((num_valid && num_ready) || (chr_valid && chr_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_radix_sweep();
		test_random(272);
		num_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
